// ----- src/flc_pkg.sv -----
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants of the frame link type classifier
// Link codes, ethertypes, header lengths and the record passed from the
// classifier front to the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

  // default configuration of the top level
  localparam int HEADER_BYTES_DEF  = 40;
  localparam int MAX_VLAN_TAGS_DEF = 4;

  // offset width covering every legal tag bound (14 + 4 * 6 = 38)
  localparam int OFF_W = 6;

  // result queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // ethertypes
  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86dd;
  localparam logic [15:0] ET_ARP    = 16'h0806;
  localparam logic [15:0] ET_VLAN_Q = 16'h8100;
  localparam logic [15:0] ET_VLAN_S = 16'h88a8;
  localparam logic [15:0] ET_VLAN_O = 16'h9100;

  // header geometry
  localparam int ETH_HDR_LEN     = 14;
  localparam int VLAN_TAG_LEN    = 4;
  localparam int COOKED1_HDR_LEN = 16;
  localparam int COOKED2_HDR_LEN = 20;
  localparam int IPV4_HDR_LEN    = 20;
  localparam int IPV6_HDR_LEN    = 40;

  // link kind codes
  typedef enum logic [2:0] {
    LINK_UNKNOWN = 3'd0,
    LINK_ETH     = 3'd1,
    LINK_RAW     = 3'd2,
    LINK_COOKED1 = 3'd3,
    LINK_COOKED2 = 3'd4
  } link_kind_t;

  // which IP length field sets the minimum frame length
  typedef enum logic [1:0] {
    ML_NONE = 2'd0,
    ML_V4   = 2'd1,
    ML_V6   = 2'd2
  } ml_sel_t;

  // one classified frame, front to back
  typedef struct packed {
    link_kind_t        kind;
    logic              found;
    logic [OFF_W-1:0]  off;
    ml_sel_t           ml_sel;
    logic [15:0]       ip_len;
    logic [15:0]       frame_len;
  } rec_t;

  function automatic logic is_ip(input logic [15:0] t);
    return t inside {ET_IPV4, ET_IPV6};
  endfunction

  function automatic logic is_ip_arp(input logic [15:0] t);
    return t inside {ET_IPV4, ET_IPV6, ET_ARP};
  endfunction

  function automatic logic is_vlan(input logic [15:0] t);
    return t inside {ET_VLAN_Q, ET_VLAN_S, ET_VLAN_O};
  endfunction

  // header position of offset candidate c: raw, cooked v1, cooked v2,
  // then ethernet with c-3 vlan tags
  function automatic int cand_pos(input int c);
    int p;
    case (c)
      0:       p = 0;
      1:       p = COOKED1_HDR_LEN;
      2:       p = COOKED2_HDR_LEN;
      default: p = ETH_HDR_LEN + VLAN_TAG_LEN * (c - 3);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- src/frame_link_type_classifier_core.sv -----
// ----------------------------------------------------------------------------
// frame_link_type_classifier_core: link type and ip header classifier
// Classifies a captured frame, fed one byte per transfer, by link type and
// finds the ip header offset and expected minimum length.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    data_byte, last_byte
//   out_     output     out_valid/out_stall  link_kind, has_ip_offset,
//                                            ip_offset, min_length,
//                                            frame_length, short_frame
//
// One byte is taken every cycle unless the queue is full; the header checks
// on a frame's last byte are done in that same cycle; the result is queued.
// A two-entry result queue and the output register part the sides: input
// stalls only when the queue is full. Reset clears the byte count, queue
// and output valid; the header store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_link_type_classifier_core #(
  parameter int HEADER_BYTES  = flc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_VLAN_TAGS = flc_pkg::MAX_VLAN_TAGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_link_kind,
  output logic             out_has_ip_offset,
  output logic [4:0]       out_ip_offset,
  output logic [16:0]      out_min_length,
  output logic [15:0]      out_frame_length,
  output logic             out_short_frame
);

  logic          q_full;
  logic          push;
  flc_pkg::rec_t rec;

  assign in_stall = q_full;

  // capture and classify
  flc_front #(
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .q_full       (q_full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .rec          (rec)
  );

  // queue and output stage
  flc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .rec               (rec),
    .q_full            (q_full),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_link_kind     (out_link_kind),
    .out_has_ip_offset (out_has_ip_offset),
    .out_ip_offset     (out_ip_offset),
    .out_min_length    (out_min_length),
    .out_frame_length  (out_frame_length),
    .out_short_frame   (out_short_frame)
  );

endmodule

`default_nettype wire

// ----- src/flc_front.sv -----
// ----------------------------------------------------------------------------
// flc_front: byte capture and header classification
// Keeps the first header bytes and a saturating byte count; on the last byte
// of a frame it classifies the header and pushes one record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_front #(
  parameter int HEADER_BYTES  = flc_pkg::HEADER_BYTES_DEF,
  parameter int MAX_VLAN_TAGS = flc_pkg::MAX_VLAN_TAGS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         q_full,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_last_byte,
  output logic              push,
  output flc_pkg::rec_t     rec
);

  localparam int IW      = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int VIEW_E  = 20 + flc_pkg::VLAN_TAG_LEN * MAX_VLAN_TAGS;
  localparam int VIEW    = (VIEW_E > 26) ? VIEW_E : 26;
  localparam int ALL     = (HEADER_BYTES > VIEW) ? HEADER_BYTES : VIEW;
  localparam int AW      = $clog2(ALL + 2);
  localparam int NC      = 4 + MAX_VLAN_TAGS;
  localparam int CW      = $clog2(NC);

  logic [7:0]    store_r [HEADER_BYTES];
  logic [15:0]   cnt_r;
  logic [15:0]   cnt_nxt;
  logic [15:0]   cnt_inc;
  logic          acc;
  logic [AW-1:0] avail;

  logic [7:0]    ext [VIEW];
  logic [15:0]   w16 [VIEW-1];

  flc_pkg::ml_sel_t         cand_sel [NC];
  logic [15:0]              cand_len [NC];
  logic [flc_pkg::OFF_W-1:0] cand_off [NC];

  flc_pkg::link_kind_t kind;
  logic                found;
  logic [CW-1:0]       cand;
  logic                eth_done;
  logic                eth_found;
  logic [CW-1:0]       eth_cand;

  assign acc     = in_valid && !q_full;
  assign cnt_inc = (cnt_r == 16'hffff) ? 16'hffff : cnt_r + 16'd1;
  assign avail   = (cnt_inc < 16'(HEADER_BYTES)) ? AW'(cnt_inc) : AW'(HEADER_BYTES);

  // header store write
  always_ff @(posedge clk) begin
    if (acc && (cnt_r < 16'(HEADER_BYTES))) begin
      store_r[cnt_r[IW-1:0]] <= in_data_byte;
    end
  end

  // byte count, cleared after the last byte
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      cnt_nxt = in_last_byte ? 16'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 16'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // header view: stored bytes plus the byte in transfer, zero past the end
  for (genvar i = 0; i < VIEW; i++) begin : g_view
    if (i < HEADER_BYTES) begin : g_in
      logic [7:0] hb;
      assign hb     = (cnt_r == 16'(i)) ? in_data_byte : store_r[i];
      assign ext[i] = (AW'(i) < avail) ? hb : 8'h00;
    end else begin : g_out
      assign ext[i] = 8'h00;
    end
  end

  // 16-bit big-endian words, zero unless both bytes are present
  for (genvar i = 0; i < VIEW - 1; i++) begin : g_word
    assign w16[i] = (AW'(i + 1) < avail) ? {ext[i], ext[i+1]} : 16'h0000;
  end

  // length field per offset candidate
  for (genvar c = 0; c < NC; c++) begin : g_cand
    localparam int P = flc_pkg::cand_pos(c);
    logic [3:0]  ver;
    logic        v4_ok;
    logic        v6_ok;
    assign ver    = ext[P][7:4];
    assign v4_ok  = (ver == 4'd4) && (w16[P+2] >= 16'(flc_pkg::IPV4_HDR_LEN));
    assign v6_ok  = (ver == 4'd6) && (AW'(P + 6) <= avail);
    assign cand_sel[c] = v4_ok ? flc_pkg::ML_V4 : (v6_ok ? flc_pkg::ML_V6 : flc_pkg::ML_NONE);
    assign cand_len[c] = v4_ok ? w16[P+2] : w16[P+4];
    assign cand_off[c] = flc_pkg::OFF_W'(P);
  end

  // ethernet vlan walk: first ethertype that is not a tag decides
  always_comb begin
    eth_done  = 1'b0;
    eth_found = 1'b0;
    eth_cand  = '0;
    for (int k = 0; k <= MAX_VLAN_TAGS; k++) begin
      if (!eth_done && !flc_pkg::is_vlan(w16[12 + 4 * k])) begin
        eth_done  = 1'b1;
        eth_found = flc_pkg::is_ip(w16[12 + 4 * k]);
        eth_cand  = CW'(3 + k);
      end
    end
  end

  // link type, in priority order, and offset candidate
  always_comb begin
    kind  = flc_pkg::LINK_UNKNOWN;
    found = 1'b0;
    cand  = '0;
    if ((avail >= AW'(20)) && flc_pkg::is_ip_arp(w16[0]) && (w16[2] == 16'h0000) &&
        (ext[11] <= 8'd8)) begin
      kind  = flc_pkg::LINK_COOKED2;
      found = flc_pkg::is_ip(w16[0]);
      cand  = CW'(2);
    end else if ((avail >= AW'(16)) && (w16[0] <= 16'd4) && (w16[4] <= 16'd8) &&
                 flc_pkg::is_ip_arp(w16[14])) begin
      kind  = flc_pkg::LINK_COOKED1;
      found = flc_pkg::is_ip(w16[14]);
      cand  = CW'(1);
    end else if ((avail >= AW'(14)) &&
                 (flc_pkg::is_ip_arp(w16[12]) || flc_pkg::is_vlan(w16[12]))) begin
      kind  = flc_pkg::LINK_ETH;
      found = eth_found;
      cand  = eth_cand;
    end else if ((ext[0][7:4] == 4'd4) || (ext[0][7:4] == 4'd6)) begin
      kind  = flc_pkg::LINK_RAW;
      found = 1'b1;
      cand  = '0;
    end
  end

  // record to the queue
  assign push          = acc && in_last_byte;
  assign rec.kind      = kind;
  assign rec.found     = found;
  assign rec.off       = found ? cand_off[cand] : '0;
  assign rec.ml_sel    = found ? cand_sel[cand] : flc_pkg::ML_NONE;
  assign rec.ip_len    = cand_len[cand];
  assign rec.frame_len = cnt_inc;

endmodule

`default_nettype wire

// ----- src/flc_back.sv -----
// ----------------------------------------------------------------------------
// flc_back: result queue and output stage
// Holds classified frames in a short queue and works out the minimum length
// and short-frame flag on the way into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire flc_pkg::rec_t rec,
  output logic               q_full,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [2:0]         out_link_kind,
  output logic               out_has_ip_offset,
  output logic [4:0]         out_ip_offset,
  output logic [16:0]        out_min_length,
  output logic [15:0]        out_frame_length,
  output logic               out_short_frame
);

  flc_pkg::rec_t                 q_mem [flc_pkg::Q_DEPTH];
  logic [flc_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [flc_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [flc_pkg::Q_PTR_W:0]     cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          pop;
  flc_pkg::rec_t                 head;
  logic [16:0]                   ml;
  logic                          short_f;

  logic [2:0]  kind_r;
  logic        found_r;
  logic [4:0]  off_r;
  logic [16:0] ml_r;
  logic [15:0] flen_r;
  logic        short_r;

  assign q_full = (cnt_r == (flc_pkg::Q_PTR_W + 1)'(flc_pkg::Q_DEPTH));
  assign pop    = (cnt_r != '0) && (!out_valid_r || !out_stall);
  assign head   = q_mem[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= rec;
    end
  end

  // queue pointers and output valid
  always_comb begin
    wr_ptr_nxt    = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt    = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt       = cnt_r + (flc_pkg::Q_PTR_W + 1)'(push) - (flc_pkg::Q_PTR_W + 1)'(pop);
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // minimum length from the ip length field
  always_comb begin
    case (head.ml_sel)
      flc_pkg::ML_V4: ml = 17'(head.off) + 17'(head.ip_len);
      flc_pkg::ML_V6: ml = 17'(head.off) + 17'(flc_pkg::IPV6_HDR_LEN) + 17'(head.ip_len);
      default:        ml = 17'd0;
    endcase
    short_f = (ml != 17'd0) && ({1'b0, head.frame_len} < ml);
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head.kind;
      found_r <= head.found;
      off_r   <= head.off[4:0];
      ml_r    <= ml;
      flen_r  <= head.frame_len;
      short_r <= short_f;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_link_kind     = kind_r;
  assign out_has_ip_offset = found_r;
  assign out_ip_offset     = off_r;
  assign out_min_length    = ml_r;
  assign out_frame_length  = flen_r;
  assign out_short_frame   = short_r;

endmodule

`default_nettype wire
